// ===== rtl/idb_pkg.sv =====
package idb_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits = 16;
  localparam int QuoWidth = DataWidth + FracBits;
  localparam int BitsPerStage = 4;
  localparam int NumStages = (QuoWidth + BitsPerStage - 1) / BitsPerStage;

  typedef logic signed [DataWidth-1:0] word_t;

  typedef struct packed {
    word_t num_low;
    word_t num_high;
    word_t den_low;
    word_t den_high;
  } in_word_t;

  typedef struct packed {
    word_t quot_low;
    word_t quot_high;
    logic  low_unbounded;
    logic  high_unbounded;
    logic  bad_interval;
  } out_word_t;

  // per-side bound selection made ahead of the dividers
  typedef struct packed {
    logic  div;
    logic  inf;
    word_t x;
    word_t y;
  } side_sel_t;

  localparam word_t MinWord = {1'b1, {(DataWidth-1){1'b0}}};
  localparam word_t MaxWord = {1'b0, {(DataWidth-1){1'b1}}};

endpackage

// ===== rtl/idb_select.sv =====
module idb_select (
  input  idb_pkg::in_word_t  in_word,
  output idb_pkg::side_sel_t sel_lo,
  output idb_pkg::side_sel_t sel_hi,
  output logic               bad
);
  import idb_pkg::*;

  word_t a, b, c, d;
  logic nn, mixed, cz, dz;

  assign a = in_word.num_low;
  assign b = in_word.num_high;
  assign c = in_word.den_low;
  assign d = in_word.den_high;
  assign cz = (c == '0);
  assign dz = (d == '0);
  assign nn = !a[DataWidth-1];
  assign mixed = a[DataWidth-1] && !b[DataWidth-1];
  assign bad = (a > b) || (c > d);

  always_comb begin
    sel_lo = '{div: 1'b0, inf: 1'b0, x: a, y: c};
    sel_hi = '{div: 1'b0, inf: 1'b0, x: b, y: c};
    if (bad) begin
    end else if (!c[DataWidth-1] && !cz) begin
      sel_lo.div = 1'b1;
      sel_hi.div = 1'b1;
      if (nn) begin
        sel_lo.y = d;
      end else if (!mixed) begin
        sel_hi.y = d;
      end
    end else if (d[DataWidth-1]) begin
      sel_lo.div = 1'b1;
      sel_hi.div = 1'b1;
      if (nn) begin
        sel_lo = '{div: 1'b1, inf: 1'b0, x: b, y: d};
        sel_hi = '{div: 1'b1, inf: 1'b0, x: a, y: c};
      end else if (mixed) begin
        sel_lo = '{div: 1'b1, inf: 1'b0, x: b, y: d};
        sel_hi = '{div: 1'b1, inf: 1'b0, x: a, y: d};
      end else begin
        sel_lo = '{div: 1'b1, inf: 1'b0, x: b, y: c};
        sel_hi = '{div: 1'b1, inf: 1'b0, x: a, y: d};
      end
    end else if (cz && !dz) begin
      if (nn) begin
        sel_lo = '{div: 1'b1, inf: 1'b0, x: a, y: d};
        sel_hi.inf = 1'b1;
      end else if (mixed) begin
        sel_lo.inf = 1'b1;
        sel_hi.inf = 1'b1;
      end else begin
        sel_lo.inf = 1'b1;
        sel_hi = '{div: 1'b1, inf: 1'b0, x: b, y: d};
      end
    end else if (c[DataWidth-1] && dz) begin
      if (nn) begin
        sel_lo.inf = 1'b1;
        sel_hi = '{div: 1'b1, inf: 1'b0, x: a, y: c};
      end else if (mixed) begin
        sel_lo.inf = 1'b1;
        sel_hi.inf = 1'b1;
      end else begin
        sel_lo = '{div: 1'b1, inf: 1'b0, x: b, y: c};
        sel_hi.inf = 1'b1;
      end
    end else begin
      sel_lo.inf = 1'b1;
      sel_hi.inf = 1'b1;
    end
  end

endmodule

// ===== rtl/idb_divider.sv =====
module idb_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  idb_pkg::side_sel_t in_sel,
  output logic               out_valid,
  output idb_pkg::word_t     out_quot,
  output logic               out_flag
);
  import idb_pkg::*;

  localparam int StW = NumStages * BitsPerStage;

  typedef struct packed {
    logic             div;
    logic             inf;
    logic             zero;
    logic             sx;
    logic             neg;
    logic [StW-1:0]   num;
    logic [DataWidth-1:0] my;
    logic [DataWidth:0]   rem;
    logic [StW-1:0]   q;
  } st_t;

  st_t  st_r [NumStages+1];
  logic vld_r [NumStages+2];
  st_t  head;
  word_t quot_r;
  logic  flag_r;

  always_comb begin
    logic [DataWidth-1:0] mx;
    mx = in_sel.x[DataWidth-1] ? DataWidth'(-in_sel.x) : in_sel.x;
    head.div = in_sel.div;
    head.inf = in_sel.inf;
    head.sx = in_sel.x[DataWidth-1];
    head.neg = in_sel.x[DataWidth-1] ^ in_sel.y[DataWidth-1];
    head.my = in_sel.y[DataWidth-1] ? DataWidth'(-in_sel.y) : in_sel.y;
    head.zero = (in_sel.y == '0);
    head.num = StW'({mx, {FracBits{1'b0}}});
    head.rem = '0;
    head.q = '0;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= head;
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_valid;
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    always_ff @(posedge clk) begin
      st_t t;
      t = st_r[s];
      for (int k = 0; k < BitsPerStage; k++) begin
        logic [DataWidth:0] r;
        r = {t.rem[DataWidth-1:0], t.num[StW-1]};
        t.num = {t.num[StW-2:0], 1'b0};
        if (r >= {1'b0, t.my}) begin
          t.rem = r - {1'b0, t.my};
          t.q = {t.q[StW-2:0], 1'b1};
        end else begin
          t.rem = r;
          t.q = {t.q[StW-2:0], 1'b0};
        end
      end
      st_r[s+1] <= t;
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else vld_r[s+1] <= vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    st_t t;
    logic [StW-1:0] lim;
    t = st_r[NumStages];
    lim = t.neg ? StW'(unsigned'(MinWord)) : StW'(unsigned'(MaxWord));
    if (t.inf) begin
      quot_r <= MinWord;
      flag_r <= 1'b1;
    end else if (!t.div) begin
      quot_r <= '0;
      flag_r <= 1'b0;
    end else if (t.zero) begin
      quot_r <= t.sx ? MinWord : MaxWord;
      flag_r <= 1'b1;
    end else if (t.q > lim) begin
      quot_r <= t.neg ? MinWord : MaxWord;
      flag_r <= 1'b1;
    end else begin
      quot_r <= t.neg ? DataWidth'(-t.q) : DataWidth'(t.q);
      flag_r <= 1'b0;
    end
    if (!rst_n) vld_r[NumStages+1] <= 1'b0;
    else vld_r[NumStages+1] <= vld_r[NumStages];
  end

  assign out_valid = vld_r[NumStages+1];
  assign out_quot = quot_r;
  assign out_flag = flag_r;

endmodule

// ===== rtl/interval_division_bounds.sv =====
// Pipeline from start to out_valid: input register, 12 divider stages of
// 4 quotient bits each, saturation register, output register.
// Throughput: one word per cycle; busy is always low.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
// The receiver cannot stall: each result shows for exactly one cycle.
module interval_division_bounds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  idb_pkg::in_word_t   in_word,
  output logic                out_valid,
  output idb_pkg::out_word_t  out_word
);
  import idb_pkg::*;

  side_sel_t sel_lo, sel_hi;
  logic bad;
  logic v_lo, v_hi, f_lo, f_hi;
  word_t q_lo, q_hi;
  logic bad_r [NumStages+2];
  logic hinf_r [NumStages+2];
  out_word_t out_r;
  logic out_vld_r;

  assign busy = 1'b0;

  idb_select u_sel (.in_word(in_word), .sel_lo(sel_lo), .sel_hi(sel_hi), .bad(bad));

  idb_divider u_div_lo (.clk(clk), .rst_n(rst_n), .in_valid(start), .in_sel(sel_lo),
    .out_valid(v_lo), .out_quot(q_lo), .out_flag(f_lo));

  idb_divider u_div_hi (.clk(clk), .rst_n(rst_n), .in_valid(start),
    .in_sel('{div: sel_hi.div, inf: sel_hi.inf, x: sel_hi.x, y: sel_hi.y}),
    .out_valid(v_hi), .out_quot(q_hi), .out_flag(f_hi));

  always_ff @(posedge clk) begin
    bad_r[0] <= bad;
    hinf_r[0] <= sel_hi.inf;
    for (int i = 1; i < NumStages + 2; i++) begin
      bad_r[i] <= bad_r[i-1];
      hinf_r[i] <= hinf_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r.quot_low <= q_lo;
    out_r.quot_high <= hinf_r[NumStages+1] ? MaxWord : q_hi;
    out_r.low_unbounded <= f_lo;
    out_r.high_unbounded <= f_hi;
    out_r.bad_interval <= bad_r[NumStages+1];
    if (!rst_n) out_vld_r <= 1'b0;
    else out_vld_r <= v_lo;
  end

  assign out_valid = out_vld_r;
  assign out_word = out_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) v_lo == v_hi)
    else $error("divider lanes out of step");
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_interval |-> !out_word.low_unbounded &&
    !out_word.high_unbounded && out_word.quot_low == '0 && out_word.quot_high == '0)
    else $error("bad interval with nonzero result");
  a_unb_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.low_unbounded |->
    (out_word.quot_low == MinWord || out_word.quot_low == MaxWord))
    else $error("flagged low bound not saturated");

endmodule
